// File: hdl/sfcs_pkg.sv
// shared types, codes and constants of the flash command sequencer
package sfcs_pkg;

  localparam int unsigned PAGE_BYTES  = 256;
  localparam int unsigned PAGE_LOG    = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W      = PAGE_LOG + 1;
  localparam int unsigned MAX_RESULTS = 10;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned ADDR_W      = 24;

  typedef enum logic [2:0] {
    OP_WRITE_START = 3'd0,
    OP_WRITE_BYTE  = 3'd1,
    OP_READ_START  = 3'd2,
    OP_ERASE       = 3'd3,
    OP_STATUS_BYTE = 3'd4,
    OP_READ_BYTE   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    KIND_SEND    = 3'd0,
    KIND_HOST    = 3'd1,
    KIND_CS      = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WDATA = 3'd1,
    MODE_WPOLL = 3'd2,
    MODE_READ  = 3'd3,
    MODE_EPOLL = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CFG_WREN_OP    = 3'd0,
    CFG_PROG_OP    = 3'd1,
    CFG_ERASE_OP   = 3'd2,
    CFG_READ_OP    = 3'd3,
    CFG_STATUS_OP  = 3'd4,
    CFG_BUSY_MASK  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [7:0]        data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

endpackage

// File: hdl/spi_flash_command_sequencer_unit.sv
// top level of the serial nor flash command sequencer
// Each host request is taken into an input register and decoded against the current mode; the
// decode writes its whole list of spi actions (one to nine entries) into a result buffer and
// updates the mode, address and counters. The buffer is then drained one entry per cycle on the
// output channel while the output is ready. A request passes through the input register and
// then the result buffer before its first result appears. A new request is taken while results
// still wait: the input register refills as soon as its request is decoded, and decode happens
// when the buffer is empty or hands over its final entry in that cycle, so single-result
// requests (data bytes inside a page chunk, busy status polls) stream at one per cycle while
// the output is ready. The configuration port is always ready; writes take effect next cycle.
module spi_flash_command_sequencer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfcs_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfcs_pkg::out_item_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import sfcs_pkg::*;

  // configuration registers
  logic [7:0] wren_op_q, prog_op_q, erase_op_q, read_op_q, status_op_q, busy_mask_q;

  // input register
  in_item_t item_q;
  logic     item_vld_q;

  // sequencer state
  mode_e             mode_q, mode_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  logic [PAGE_W-1:0] chunk_q, chunk_d;

  // result buffer, entry 0 is presented on the output
  out_item_t        res_q [MAX_RESULTS];
  logic [CNT_W-1:0] cnt_q;

  // decode results
  out_item_t        lst [MAX_RESULTS];
  logic [CNT_W-1:0] lst_n;

  logic pop, buf_free, proc, busy;

  function automatic out_item_t mk(kind_e k, logic [7:0] v);
    out_item_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    return r;
  endfunction

  // bytes left in the page from a, capped by what is still to be written
  function automatic logic [PAGE_W-1:0] chunk_len(logic [ADDR_W-1:0] a,
                                                  logic [ADDR_W-1:0] r);
    logic [PAGE_W-1:0] room;
    room = PAGE_W'(PAGE_BYTES) - {1'b0, a[PAGE_LOG-1:0]};
    if (r < ADDR_W'(room)) begin
      return r[PAGE_W-1:0];
    end
    return room;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = res_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // buffer can take a fresh list when empty or when its final entry leaves now
  assign buf_free    = (cnt_q == '0) || (cnt_q == CNT_W'(1) && pop);
  assign proc        = item_vld_q && buf_free;
  assign in_ready_o  = !item_vld_q || proc;

  // flash busy only when every mask bit is set, an empty mask never means busy
  assign busy = (busy_mask_q != 8'h00) &&
                ((item_q.data_byte & busy_mask_q) == busy_mask_q);

  // decode of one request into its list of actions
  always_comb begin
    mode_d  = mode_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    lst_n   = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      lst[i] = mk(KIND_SEND, 8'h00);
    end

    if (item_q.op == OP_WRITE_START && mode_q == MODE_IDLE) begin
      if (item_q.length == '0) begin
        lst[0] = mk(KIND_DONE, 8'h00);
        lst_n  = CNT_W'(1);
      end else begin
        addr_d  = item_q.address;
        rem_d   = item_q.length;
        chunk_d = chunk_len(item_q.address, item_q.length);
        lst[0]  = mk(KIND_SEND, wren_op_q);
        lst[1]  = mk(KIND_CS, 8'h00);
        lst[2]  = mk(KIND_SEND, prog_op_q);
        lst[3]  = mk(KIND_SEND, item_q.address[23:16]);
        lst[4]  = mk(KIND_SEND, item_q.address[15:8]);
        lst[5]  = mk(KIND_SEND, item_q.address[7:0]);
        lst_n   = CNT_W'(6);
        mode_d  = MODE_WDATA;
      end
    end else if (item_q.op == OP_WRITE_BYTE && mode_q == MODE_WDATA) begin
      lst[0]  = mk(KIND_SEND, item_q.data_byte);
      addr_d  = addr_q + ADDR_W'(1);
      rem_d   = rem_q - ADDR_W'(1);
      chunk_d = chunk_q - PAGE_W'(1);
      if (chunk_q == PAGE_W'(1)) begin
        // page chunk complete, close frame and start polling
        lst[1] = mk(KIND_CS, 8'h00);
        lst[2] = mk(KIND_SEND, status_op_q);
        lst[3] = mk(KIND_SEND, 8'h00);
        lst_n  = CNT_W'(4);
        mode_d = MODE_WPOLL;
      end else begin
        lst_n  = CNT_W'(1);
      end
    end else if (item_q.op == OP_READ_START && mode_q == MODE_IDLE) begin
      lst[0] = mk(KIND_SEND, read_op_q);
      lst[1] = mk(KIND_SEND, item_q.address[23:16]);
      lst[2] = mk(KIND_SEND, item_q.address[15:8]);
      lst[3] = mk(KIND_SEND, item_q.address[7:0]);
      addr_d = item_q.address;
      rem_d  = item_q.length;
      if (item_q.length == '0) begin
        lst[4] = mk(KIND_CS, 8'h00);
        lst[5] = mk(KIND_DONE, 8'h00);
        lst_n  = CNT_W'(6);
      end else begin
        lst[4] = mk(KIND_SEND, 8'h00);
        lst_n  = CNT_W'(5);
        mode_d = MODE_READ;
      end
    end else if (item_q.op == OP_ERASE && mode_q == MODE_IDLE) begin
      addr_d = item_q.address;
      lst[0] = mk(KIND_SEND, wren_op_q);
      lst[1] = mk(KIND_CS, 8'h00);
      lst[2] = mk(KIND_SEND, erase_op_q);
      lst[3] = mk(KIND_SEND, item_q.address[23:16]);
      lst[4] = mk(KIND_SEND, item_q.address[15:8]);
      lst[5] = mk(KIND_SEND, item_q.address[7:0]);
      lst[6] = mk(KIND_CS, 8'h00);
      lst[7] = mk(KIND_SEND, status_op_q);
      lst[8] = mk(KIND_SEND, 8'h00);
      lst_n  = CNT_W'(9);
      mode_d = MODE_EPOLL;
    end else if (item_q.op == OP_STATUS_BYTE &&
                 (mode_q == MODE_WPOLL || mode_q == MODE_EPOLL)) begin
      if (busy) begin
        lst[0] = mk(KIND_SEND, 8'h00);
        lst_n  = CNT_W'(1);
      end else begin
        lst[0] = mk(KIND_CS, 8'h00);
        if (mode_q == MODE_WPOLL && rem_q != '0) begin
          // next page chunk
          chunk_d = chunk_len(addr_q, rem_q);
          lst[1]  = mk(KIND_SEND, wren_op_q);
          lst[2]  = mk(KIND_CS, 8'h00);
          lst[3]  = mk(KIND_SEND, prog_op_q);
          lst[4]  = mk(KIND_SEND, addr_q[23:16]);
          lst[5]  = mk(KIND_SEND, addr_q[15:8]);
          lst[6]  = mk(KIND_SEND, addr_q[7:0]);
          lst_n   = CNT_W'(7);
          mode_d  = MODE_WDATA;
        end else begin
          lst[1] = mk(KIND_DONE, 8'h00);
          lst_n  = CNT_W'(2);
          mode_d = MODE_IDLE;
        end
      end
    end else if (item_q.op == OP_READ_BYTE && mode_q == MODE_READ) begin
      lst[0] = mk(KIND_HOST, item_q.data_byte);
      addr_d = addr_q + ADDR_W'(1);
      rem_d  = rem_q - ADDR_W'(1);
      if (rem_q != ADDR_W'(1)) begin
        lst[1] = mk(KIND_SEND, 8'h00);
        lst_n  = CNT_W'(2);
      end else begin
        lst[1] = mk(KIND_CS, 8'h00);
        lst[2] = mk(KIND_DONE, 8'h00);
        lst_n  = CNT_W'(3);
        mode_d = MODE_IDLE;
      end
    end else begin
      // op unknown or not allowed in this mode
      lst[0] = mk(KIND_REJECT, 8'h00);
      lst_n  = CNT_W'(1);
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      lst[i].last = (CNT_W'(i) == lst_n - CNT_W'(1));
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wren_op_q   <= 8'd6;
      prog_op_q   <= 8'd2;
      erase_op_q  <= 8'd32;
      read_op_q   <= 8'd3;
      status_op_q <= 8'd5;
      busy_mask_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WREN_OP:   wren_op_q   <= cfg_data_i;
        CFG_PROG_OP:   prog_op_q   <= cfg_data_i;
        CFG_ERASE_OP:  erase_op_q  <= cfg_data_i;
        CFG_READ_OP:   read_op_q   <= cfg_data_i;
        CFG_STATUS_OP: status_op_q <= cfg_data_i;
        CFG_BUSY_MASK: busy_mask_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // control state: input valid, sequencer mode and counters, buffer fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      addr_q     <= '0;
      rem_q      <= '0;
      chunk_q    <= '0;
      cnt_q      <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        item_vld_q <= 1'b1;
      end else if (proc) begin
        item_vld_q <= 1'b0;
      end
      if (proc) begin
        mode_q  <= mode_d;
        addr_q  <= addr_d;
        rem_q   <= rem_d;
        chunk_q <= chunk_d;
        cnt_q   <= lst_n;
      end else if (pop) begin
        cnt_q   <= cnt_q - CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (proc) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_q[i] <= lst[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_q[i] <= res_q[i + 1];
      end
    end
  end

  // a decoded request always leaves results to deliver
  a_proc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_o)
    else $error("decoded request left the result buffer empty");

  // the buffer never holds more than one list
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result buffer overfilled");

  // a rejected request gives exactly one result
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_REJECT) |-> out_data_o.last)
    else $error("reject result not marked last");

  // while taking data bytes the page chunk is never exhausted
  a_chunk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_WDATA) |-> (chunk_q != '0))
    else $error("write data mode with empty chunk");

endmodule
